FILE: rtl/lfd_pkg.sv
// ----------------------------------------------------------------------------
// lfd_pkg
// Shared types, constants and the crc-8 step of the length-framed deframer.
// ----------------------------------------------------------------------------
package lfd_pkg;

    localparam int unsigned BUFFER_BYTES = 128;
    localparam int unsigned BUF_AW       = $clog2(BUFFER_BYTES);

    localparam logic [7:0] STX_BYTE      = 8'h02;
    localparam logic [7:0] ETX_BYTE      = 8'h04;
    localparam logic [7:0] CRC_POLY      = 8'h8C;
    localparam logic [7:0] MAX_LEN_RST   = 8'd105;

    localparam logic [2:0] HDR_ONE_BYTE  = 3'd5;
    localparam logic [2:0] HDR_TWO_BYTE  = 3'd6;
    localparam logic [2:0] HDR_LONG      = 3'd7;

    localparam logic [1:0] REG_MAX_FRAME_LEN = 2'd0;

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_CRC  = 2'd1,
        ERR_LEN  = 2'd2,
        ERR_RSVD = 2'd3
    } t_err;

    typedef struct packed {
        logic       accepted;
        logic       read_valid;
        logic       rd_ok;
        logic       packet_open;
        t_err       error_status;
        logic [7:0] available_bytes;
    } t_result;

    // reflected crc-8, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] din);
        logic [7:0] c;
        c = crc ^ din;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/lfd_store.sv
// ----------------------------------------------------------------------------
// lfd_store
// Payload byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lfd_store (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [lfd_pkg::BUF_AW-1:0] i_waddr,
    input  logic [7:0]                 i_wdata,
    input  logic                       i_re,
    input  logic [lfd_pkg::BUF_AW-1:0] i_raddr,
    output logic [7:0]                 o_rdata
);
    import lfd_pkg::*;

    logic [7:0] r_mem [BUFFER_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/length_framed_deframer_crc8.sv
// ----------------------------------------------------------------------------
// length_framed_deframer_crc8
// Length-framed byte deframer with crc-8 check and a payload pop port.
//
//   channel   dir  contents
//   s_axis    in   tuser = func, tdata = received byte
//   m_axis    out  one status/result request per input request
//   apb       in   max_frame_len at address 0
//
// One request per cycle sustained while m_axis is not stalled; after acceptance the
// result passes the control update plus store read stage, then the output register.
// The store read port bounds the latency; control state is in flops.
// Reset is synchronous; the store needs no clearing pass.
// A stall on m_axis holds the output register, then the store read stage.
// ----------------------------------------------------------------------------
module length_framed_deframer_crc8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] accepted, [1] read_valid, [9:2] read_data, [10] packet_open,
    // [12:11] error_status, [20:13] available_bytes, [23:21] zero
    output logic [23:0] m_axis_tdata
);
    import lfd_pkg::*;

    logic [7:0]  r_max, n_max;
    logic        r_open, n_open;
    logic [7:0]  r_bc, n_bc;
    logic [7:0]  r_lbl, n_lbl;
    logic [15:0] r_flen, n_flen;
    logic [2:0]  r_hs, n_hs;
    logic [7:0]  r_si, n_si;
    logic [7:0]  r_pc, n_pc;
    t_err        r_err, n_err;
    logic [7:0]  r_crc, n_crc;

    logic        r_s1_valid;
    t_result     r_s1_res;
    logic        r_o_valid;
    logic [23:0] r_o_data;

    t_func       func;
    logic        in_go, s1_go;
    logic        we, re;
    t_result     res;
    logic [15:0] flen_acc;
    logic [7:0]  rd_byte;
    logic [7:0]  mem_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_MAX_FRAME_LEN) ? {24'd0, r_max} : 32'd0;

    always_comb begin
        n_max = r_max;
        if (psel && penable && pwrite && paddr == REG_MAX_FRAME_LEN) begin
            n_max = pwdata[7:0];
        end
    end

    assign func          = t_func'(s_axis_tuser);
    assign s1_go         = r_s1_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign in_go         = s_axis_tvalid && s_axis_tready;

    // control update for one request
    always_comb begin
        n_open   = r_open;
        n_bc     = r_bc;
        n_lbl    = r_lbl;
        n_flen   = r_flen;
        n_hs     = r_hs;
        n_si     = r_si;
        n_pc     = r_pc;
        n_err    = r_err;
        n_crc    = r_crc;
        we       = 1'b0;
        re       = 1'b0;
        flen_acc = (r_flen[15:8] != 8'd0) ? 16'hFFFF : {r_flen[7:0], s_axis_tdata};
        res      = '0;
        unique case (func)
            FUNC_PUSH: begin
                if (r_bc >= r_max || r_err != ERR_NONE) begin
                    res.accepted = 1'b0;
                end else if (!r_open) begin
                    if (r_bc == 8'd0 && s_axis_tdata == STX_BYTE) begin
                        n_open       = 1'b1;
                        n_bc         = r_bc + 8'd1;
                        res.accepted = 1'b1;
                    end
                end else if (r_flen == 16'd0 || r_lbl != 8'd0) begin
                    if (r_lbl == 8'd0) begin
                        n_lbl        = s_axis_tdata;
                        n_hs         = (s_axis_tdata == 8'd1) ? HDR_ONE_BYTE :
                                       (s_axis_tdata == 8'd2) ? HDR_TWO_BYTE : HDR_LONG;
                        n_bc         = r_bc + 8'd1;
                        res.accepted = 1'b1;
                    end else begin
                        n_flen = flen_acc;
                        n_lbl  = r_lbl - 8'd1;
                        if (r_lbl != 8'd1) begin
                            n_bc         = r_bc + 8'd1;
                            res.accepted = 1'b1;
                        end else if (flen_acc > {8'd0, r_max} ||
                                     flen_acc < {13'd0, r_hs}) begin
                            n_open = 1'b0;
                            n_err  = ERR_LEN;
                        end else begin
                            n_bc         = r_bc + 8'd1;
                            res.accepted = 1'b1;
                        end
                    end
                end else if ({8'd0, r_bc} + 16'd1 < r_flen) begin
                    we           = ({8'd0, r_si} < 16'(BUFFER_BYTES));
                    n_si         = r_si + 8'd1;
                    n_crc        = crc8_step(r_crc, s_axis_tdata);
                    n_bc         = r_bc + 8'd1;
                    res.accepted = 1'b1;
                end else begin
                    n_open = 1'b0;
                    n_bc   = r_bc + 8'd1;
                    if (s_axis_tdata != ETX_BYTE) begin
                        n_err = ERR_LEN;
                    end else if (r_si == 8'd0 ||
                                 {2'd0, n_bc} + 10'd1 != {2'd0, r_si} + {7'd0, r_hs}) begin
                        n_err = ERR_LEN;
                    end else begin
                        n_pc = r_si - 8'd1;
                        if (r_crc != 8'd0) begin
                            n_err = ERR_CRC;
                        end else begin
                            n_si         = 8'd0;
                            res.accepted = 1'b1;
                        end
                    end
                end
            end
            FUNC_POP: begin
                if (!r_open && r_err == ERR_NONE && r_si < r_pc) begin
                    re             = ({8'd0, r_si} < 16'(BUFFER_BYTES));
                    res.read_valid = 1'b1;
                    res.rd_ok      = ({8'd0, r_si} < 16'(BUFFER_BYTES));
                    n_si           = r_si + 8'd1;
                end
            end
            FUNC_CLEAR: begin
                n_open = 1'b0;
                n_bc   = 8'd0;
                n_lbl  = 8'd0;
                n_flen = 16'd0;
                n_hs   = 3'd0;
                n_si   = 8'd0;
                n_pc   = 8'd0;
                n_err  = ERR_NONE;
                n_crc  = 8'd0;
            end
            FUNC_NOP: begin
                res.accepted = 1'b0;
            end
        endcase
        res.packet_open  = n_open;
        res.error_status = n_err;
        if (!n_open && n_err == ERR_NONE && n_pc > n_si) begin
            res.available_bytes = n_pc - n_si;
        end
    end

    lfd_store u_store (
        .i_clk   (i_clk),
        .i_we    (in_go && we),
        .i_waddr (r_si[BUF_AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (in_go && re),
        .i_raddr (r_si[BUF_AW-1:0]),
        .o_rdata (mem_rdata)
    );

    assign rd_byte = r_s1_res.rd_ok ? mem_rdata : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max      <= MAX_LEN_RST;
            r_open     <= 1'b0;
            r_bc       <= 8'd0;
            r_lbl      <= 8'd0;
            r_flen     <= 16'd0;
            r_hs       <= 3'd0;
            r_si       <= 8'd0;
            r_pc       <= 8'd0;
            r_err      <= ERR_NONE;
            r_crc      <= 8'd0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_max <= n_max;
            if (in_go) begin
                r_open <= n_open;
                r_bc   <= n_bc;
                r_lbl  <= n_lbl;
                r_flen <= n_flen;
                r_hs   <= n_hs;
                r_si   <= n_si;
                r_pc   <= n_pc;
                r_err  <= n_err;
                r_crc  <= n_crc;
            end
            if (in_go) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_s1_res <= res;
        end
        if (s1_go) begin
            r_o_data <= {3'd0, r_s1_res.available_bytes, r_s1_res.error_status,
                         r_s1_res.packet_open, rd_byte, r_s1_res.read_valid,
                         r_s1_res.accepted};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

endmodule

FILE: tb/tb_length_framed_deframer_crc8.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_length_framed_deframer_crc8
// Self-checking bench for the length-framed deframer. A short scripted
// sequence covers reset state, a good frame and its pops, length saturation
// and a too-short length. It is followed by hand-built frames with bad crc,
// bad end byte, zero and wide count bytes. Random frames and noise then run
// under several frame-length limits and idle patterns. Each status result
// is checked against an in-bench model of the deframer or a pinned script value.
// ----------------------------------------------------------------------------
module tb_length_framed_deframer_crc8;
    import lfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned PHASE_USEFUL = 95;
    localparam int unsigned PHASE_CAP    = 230;

    typedef struct packed {
        logic       acc;
        logic       rv;
        logic [7:0] rd;
        logic       popen;
        t_err       err;
        logic [7:0] avail;
    } t_res;

    typedef struct packed {
        t_func      f;
        logic [7:0] d;
        logic       pinned;
        t_res       res;
    } t_row;

    typedef enum int {
        FAULT_NONE,
        FAULT_CRC,
        FAULT_END,
        FAULT_LONG,
        FAULT_SHORT,
        FAULT_ZERO_COUNT,
        FAULT_WIDE_COUNT,
        FAULT_JUNK,
        FAULT_TRUNC
    } t_fault;

    localparam t_res R_NONE = '0;
    localparam t_res R_OPEN = '{1'b1, 1'b0, 8'h00, 1'b1, ERR_NONE, 8'd0};
    localparam t_res R_LEN  = '{1'b0, 1'b0, 8'h00, 1'b0, ERR_LEN, 8'd0};

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data
    logic [1:0]  s_axis_tuser;   // [1:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [0] accepted, [1] read_valid, [9:2] read_data, [10] packet_open,
    // [12:11] error_status, [20:13] available_bytes
    logic [23:0] m_axis_tdata;

    // deframer model state
    logic [7:0]  len_limit;
    logic [7:0]  pay_mem [BUFFER_BYTES];
    bit          in_frame;
    int unsigned taken;
    int unsigned len_left;
    int unsigned frm_len;
    int unsigned hdr_len;
    int unsigned buf_idx;
    int unsigned pay_cnt;
    t_err        frm_err;
    logic [7:0]  crc_acc;

    t_res        status_q [$];
    bit          pin_row;
    t_res        pin_res;
    int unsigned useful_cnt;
    int unsigned sent_cnt;
    int unsigned bad_cnt;
    int unsigned cycle_cnt;
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned len_plan [8] = '{128, 1, 6, 40, 105, 2, 90, 128};
    t_row        script [26];

    length_framed_deframer_crc8 DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = {1'b0, c[7:1]} ^ (c[0] ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic void clear_frame_state();
        in_frame = 1'b0;
        taken    = 0;
        len_left = 0;
        frm_len  = 0;
        hdr_len  = 0;
        buf_idx  = 0;
        pay_cnt  = 0;
        frm_err  = ERR_NONE;
        crc_acc  = 8'h00;
    endfunction

    function automatic t_res deframe_step(t_func f, logic [7:0] d);
        t_res r;
        bit   readable;
        r = R_NONE;
        readable = !in_frame && frm_err == ERR_NONE;
        case (f)
            FUNC_PUSH: begin
                if (taken < len_limit && frm_err == ERR_NONE) begin
                    if (!in_frame) begin
                        if (taken == 0 && d == STX_BYTE) begin
                            in_frame = 1'b1;
                            taken++;
                            r.acc = 1'b1;
                        end
                    end else if (frm_len == 0 || len_left > 0) begin
                        if (len_left == 0) begin
                            len_left = d;
                            hdr_len  = (d == 8'd1) ? HDR_ONE_BYTE :
                                       ((d == 8'd2) ? HDR_TWO_BYTE : HDR_LONG);
                            taken++;
                            r.acc = 1'b1;
                        end else begin
                            frm_len = (frm_len << 8) + d;
                            if (frm_len > 32'hFFFF) frm_len = 32'hFFFF;
                            len_left--;
                            if (len_left > 0) begin
                                taken++;
                                r.acc = 1'b1;
                            end else if (frm_len > len_limit || frm_len < hdr_len) begin
                                in_frame = 1'b0;
                                frm_err  = ERR_LEN;
                            end else begin
                                taken++;
                                r.acc = 1'b1;
                            end
                        end
                    end else if (taken + 1 < frm_len) begin
                        if (buf_idx < BUFFER_BYTES) pay_mem[buf_idx] = d;
                        buf_idx = (buf_idx + 1) & 32'hFF;
                        crc_acc = crc8_next(crc_acc, d);
                        taken++;
                        r.acc = 1'b1;
                    end else begin
                        in_frame = 1'b0;
                        taken++;
                        if (d != ETX_BYTE) begin
                            frm_err = ERR_LEN;
                        end else if (buf_idx == 0 ||
                                     int'(taken) - int'(hdr_len) != int'(buf_idx) - 1) begin
                            frm_err = ERR_LEN;
                        end else begin
                            pay_cnt = buf_idx - 1;
                            if (crc_acc != 8'h00) begin
                                frm_err = ERR_CRC;
                            end else begin
                                buf_idx = 0;
                                r.acc   = 1'b1;
                            end
                        end
                    end
                end
            end
            FUNC_POP: begin
                if (readable && buf_idx < pay_cnt) begin
                    r.rv = 1'b1;
                    r.rd = (buf_idx < BUFFER_BYTES) ? pay_mem[buf_idx] : 8'h00;
                    buf_idx++;
                end
            end
            FUNC_CLEAR: begin
                clear_frame_state();
            end
            default: begin
            end
        endcase
        r.popen = in_frame;
        r.err   = frm_err;
        if (!in_frame && frm_err == ERR_NONE && pay_cnt > buf_idx) r.avail = 8'(pay_cnt - buf_idx);
        return r;
    endfunction

    task automatic send_req(t_func f, logic [7:0] d);
        t_res r;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        r = deframe_step(f, d);
        sent_cnt++;
        if (r.acc || r.rv || f == FUNC_CLEAR) useful_cnt++;
        if (pin_row) r = pin_res;
        pin_row = 1'b0;
        status_q.push_back(r);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_max_len(logic [7:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MAX_FRAME_LEN;
        pwdata  <= {24'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        len_limit = v;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_frame(int unsigned n, int unsigned plen, t_fault flt);
        logic [7:0]  fb [$];
        logic [7:0]  crc;
        logic [7:0]  b;
        int unsigned flen_v;
        int unsigned hdr_v;
        fb  = {};
        crc = 8'h00;
        fb.push_back(STX_BYTE);
        if (flt == FAULT_ZERO_COUNT) repeat ($urandom_range(1, 2)) fb.push_back(8'h00);
        fb.push_back(8'(n));
        hdr_v = (n == 1) ? 5 : ((n == 2) ? 6 : 7);
        case (flt)
            FAULT_LONG:  flen_v = (n == 1) ? $urandom_range(int'(len_limit) + 1, 255) : $urandom;
            FAULT_SHORT: flen_v = $urandom_range(0, hdr_v - 1);
            default:     flen_v = plen + 4 + n;
        endcase
        for (int i = int'(n); i > 0; i--) begin
            fb.push_back((i <= 4) ? 8'(flen_v >> (8 * (i - 1))) : 8'h00);
        end
        repeat (plen) begin
            b = 8'($urandom);
            fb.push_back(b);
            crc = crc8_next(crc, b);
        end
        fb.push_back((flt == FAULT_CRC) ? (crc ^ 8'($urandom_range(1, 255))) : crc);
        b = 8'($urandom);
        if (b == ETX_BYTE) b = ~b;
        fb.push_back((flt == FAULT_END) ? b : ETX_BYTE);
        if (flt == FAULT_JUNK) fb[$urandom_range(0, fb.size() - 1)] = 8'($urandom);
        if (flt == FAULT_TRUNC) repeat ($urandom_range(1, fb.size() - 1)) void'(fb.pop_back());
        foreach (fb[k]) begin
            if ($urandom_range(0, 15) == 0)
                send_req($urandom_range(0, 1) ? FUNC_POP : FUNC_NOP, 8'($urandom));
            send_req(FUNC_PUSH, fb[k]);
        end
        repeat (plen + $urandom_range(0, 2)) send_req(FUNC_POP, 8'($urandom));
    endtask

    task automatic report_bad(t_res want, t_res got, bit orphan);
        bad_cnt++;
        if (bad_cnt <= 10) begin
            if (orphan) begin
                $display("unexpected result acc=%0d rv=%0d rd=%02h open=%0d err=%0d avail=%0d",
                         got.acc, got.rv, got.rd, got.popen, got.err, got.avail);
            end else begin
                $write("mismatch exp acc=%0d rv=%0d rd=%02h open=%0d err=%0d avail=%0d",
                       want.acc, want.rv, want.rd, want.popen, want.err, want.avail);
                $display(" | got acc=%0d rv=%0d rd=%02h open=%0d err=%0d avail=%0d",
                         got.acc, got.rv, got.rd, got.popen, got.err, got.avail);
            end
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_res got;
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[9:2], m_axis_tdata[10],
                    t_err'(m_axis_tdata[12:11]), m_axis_tdata[20:13]};
            if (status_q.size() == 0) begin
                report_bad(R_NONE, got, 1'b1);
            end else begin
                want = status_q.pop_front();
                if (got.acc !== want.acc || got.rv !== want.rv || got.rd !== want.rd ||
                    got.popen !== want.popen || got.err !== want.err ||
                    got.avail !== want.avail)
                    report_bad(want, got, 1'b0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned n;
        int unsigned plen;
        int          max_pl;
        int unsigned w;
        t_fault      flt;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 2'd0;
        pwdata        = 32'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = FUNC_NOP;
        m_axis_tready = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        pin_row       = 1'b0;
        pin_res       = R_NONE;
        useful_cnt    = 0;
        sent_cnt      = 0;
        bad_cnt       = 0;
        cycle_cnt     = 0;
        len_limit     = MAX_LEN_RST;
        clear_frame_state();

        script = '{
            '{FUNC_POP,   8'h00,    1'b1, R_NONE},
            '{FUNC_NOP,   8'hFF,    1'b1, R_NONE},
            '{FUNC_PUSH,  8'h55,    1'b1, R_NONE},
            '{FUNC_PUSH,  STX_BYTE, 1'b1, R_OPEN},
            '{FUNC_PUSH,  8'h01,    1'b1, R_OPEN},
            '{FUNC_PUSH,  8'h07,    1'b1, R_OPEN},
            '{FUNC_PUSH,  8'h00,    1'b1, R_OPEN},
            '{FUNC_PUSH,  8'hFF,    1'b1, R_OPEN},
            '{FUNC_PUSH,  crc8_next(crc8_next(8'h00, 8'h00), 8'hFF), 1'b0, R_NONE},
            '{FUNC_PUSH,  ETX_BYTE, 1'b0, R_NONE},
            '{FUNC_PUSH,  STX_BYTE, 1'b1, '{1'b0, 1'b0, 8'h00, 1'b0, ERR_NONE, 8'd2}},
            '{FUNC_POP,   8'h00,    1'b1, '{1'b0, 1'b1, 8'h00, 1'b0, ERR_NONE, 8'd1}},
            '{FUNC_POP,   8'h00,    1'b1, '{1'b0, 1'b1, 8'hFF, 1'b0, ERR_NONE, 8'd0}},
            '{FUNC_POP,   8'h00,    1'b1, R_NONE},
            '{FUNC_CLEAR, 8'h00,    1'b1, R_NONE},
            '{FUNC_PUSH,  STX_BYTE, 1'b1, R_OPEN},
            '{FUNC_PUSH,  8'h03,    1'b1, R_OPEN},
            '{FUNC_PUSH,  8'hFF,    1'b1, R_OPEN},
            '{FUNC_PUSH,  8'hFF,    1'b1, R_OPEN},
            '{FUNC_PUSH,  8'hFF,    1'b1, R_LEN},
            '{FUNC_PUSH,  ETX_BYTE, 1'b1, R_LEN},
            '{FUNC_CLEAR, 8'h00,    1'b1, R_NONE},
            '{FUNC_PUSH,  STX_BYTE, 1'b1, R_OPEN},
            '{FUNC_PUSH,  8'h01,    1'b1, R_OPEN},
            '{FUNC_PUSH,  8'h03,    1'b1, R_LEN},
            '{FUNC_CLEAR, 8'h00,    1'b1, R_NONE}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            pin_row = script[i].pinned;
            pin_res = script[i].res;
            send_req(script[i].f, script[i].d);
        end

        idle_pct  = 13;
        stall_pct = 13;
        send_req(FUNC_CLEAR, 8'h00);
        send_frame(1, 3, FAULT_CRC);
        send_req(FUNC_CLEAR, 8'h00);
        send_frame(2, 4, FAULT_END);
        send_req(FUNC_CLEAR, 8'h00);
        send_frame(1, 2, FAULT_ZERO_COUNT);
        send_req(FUNC_CLEAR, 8'h00);
        send_frame(4, 3, FAULT_WIDE_COUNT);
        send_req(FUNC_CLEAR, 8'h00);
        send_frame(3, 5, FAULT_NONE);
        send_req(FUNC_CLEAR, 8'h00);
        send_frame(2, 0, FAULT_NONE);

        for (int p = 0; p < 8; p++) begin
            settle();
            write_max_len(8'(len_plan[p]));
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            useful_cnt = 0;
            sent_cnt   = 0;
            while (useful_cnt < PHASE_USEFUL && sent_cnt < PHASE_CAP) begin
                if ($urandom_range(0, 99) < 85) begin
                    if ($urandom_range(0, 9) != 0) send_req(FUNC_CLEAR, 8'($urandom));
                    w = $urandom_range(0, 9);
                    n = (w < 5) ? 1 : ((w < 8) ? 2 : 3);
                    flt = ($urandom_range(0, 99) < 70) ? FAULT_NONE :
                          t_fault'($urandom_range(FAULT_CRC, FAULT_TRUNC));
                    if (flt == FAULT_WIDE_COUNT) n = $urandom_range(4, 6);
                    max_pl = int'(len_limit) - 4 - int'(n);
                    if (max_pl < 0) max_pl = 0;
                    if ($urandom_range(0, 7) == 0)
                        plen = $urandom_range(0, max_pl);
                    else
                        plen = $urandom_range(0, (max_pl < 12) ? max_pl : 12);
                    send_frame(n, plen, flt);
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_req(t_func'($urandom_range(0, 3)), 8'($urandom));
                end
            end
        end

        settle();
        if (bad_cnt == 0 && status_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/lfd_pkg.sv
rtl/lfd_store.sv
rtl/length_framed_deframer_crc8.sv
tb/tb_length_framed_deframer_crc8.sv
